>>> rtl/bdf2_pkg.sv
// shared types and fixed-point constants for the direct form II biquad
package bdf2_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC_BITS = 28;
   localparam int STATE_BITS     = 32;

   localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
   localparam int STATE_FRAC  = STATE_BITS - 8;
   localparam int ACC_FRAC    = COEF_FRAC_BITS + STATE_FRAC;

   // product of one coefficient and one state word
   localparam int PROD_BITS = COEF_BITS + STATE_BITS;
   // three products plus the aligned input, with a spare guard bit
   localparam int ACC_BITS  = PROD_BITS + 3;

   // alignment shifts between formats
   localparam int X_SHIFT = ACC_FRAC - SAMPLE_FRAC;
   localparam int D_SHIFT = ACC_FRAC - STATE_FRAC;
   localparam int Y_SHIFT = ACC_FRAC - SAMPLE_FRAC;

   localparam logic [ACC_BITS-1:0] D_HALF = ACC_BITS'(1) << (D_SHIFT - 1);
   localparam logic [ACC_BITS-1:0] Y_HALF = ACC_BITS'(1) << (Y_SHIFT - 1);

   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

   // register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A2 = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
      logic                          last_out;
   } rsp_payload_type;

endpackage

>>> rtl/biquad_df2_filter_unit.sv
// direct form II biquad section around one shared multiply-accumulate unit
//
//   channel  direction  ports                               moves
//   req      in         req_valid req_ready req_payload     one sample per request
//   rsp      out        rsp_valid rsp_ready rsp_payload     one filtered sample
//   csr      in         csr_valid csr_ready csr_index/data  one coefficient write
//
// a request runs through all the sequencer steps before the next one is taken: the single
// 32x32 multiplier is used five times, each product registered before it is
// accumulated, plus one step each to narrow the node and the output.
// reset (synchronous, active high) clears the delay words and loads b0 = 1.0.
// the result sits in an output register; a new request is taken while it waits,
// and only the final narrowing step holds if the previous result is still there.
module biquad_df2_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bdf2_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bdf2_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdf2_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdf2_pkg::COEF_BITS-1:0]    csr_data
);
   import bdf2_pkg::*;

   // sequencer steps
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL_A1 = 4'd1;  // prod = a1*w1
   localparam logic [3:0] ST_MUL_A2 = 4'd2;  // acc -= prod, prod = a2*w2
   localparam logic [3:0] ST_SUB_A2 = 4'd3;  // acc -= prod
   localparam logic [3:0] ST_NODE   = 4'd4;  // narrow acc into d
   localparam logic [3:0] ST_MUL_B0 = 4'd5;  // prod = b0*d
   localparam logic [3:0] ST_MUL_B1 = 4'd6;  // acc += prod, prod = b1*w1
   localparam logic [3:0] ST_MUL_B2 = 4'd7;  // acc += prod, prod = b2*w2
   localparam logic [3:0] ST_ADD_B2 = 4'd8;  // acc += prod
   localparam logic [3:0] ST_OUT    = 4'd9;  // narrow acc into y, shift delay line

   logic [3:0] state_ff, state_in;

   logic signed [COEF_BITS-1:0]  b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [STATE_BITS-1:0] w1_ff, w1_in, w2_ff, w2_in, d_ff, d_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                         clip_ff, clip_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_payload_ff, rsp_payload_in;

   // shared multiplier operands
   logic signed [COEF_BITS-1:0]  mul_coef;
   logic signed [STATE_BITS-1:0] mul_word;
   logic signed [PROD_BITS-1:0]  mul_result;

   // narrowing of the accumulator
   logic [ACC_BITS-1:0]                          d_round, y_round;
   logic [ACC_BITS-D_SHIFT-STATE_BITS:0]         d_upper;
   logic [ACC_BITS-Y_SHIFT-SAMPLE_BITS:0]        y_upper;
   logic                                         d_fits, y_fits;
   logic signed [STATE_BITS-1:0]                 d_sat;
   logic signed [SAMPLE_BITS-1:0]                y_sat;

   logic req_fire, rsp_fire, out_hold;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid_ff && rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   // the previous result still waits, so the output step holds
   assign out_hold = rsp_valid_ff && !rsp_ready;

   // operand select for the one multiplier
   always_comb begin
      mul_coef = a1_ff;
      mul_word = w1_ff;
      case (state_ff)
         ST_MUL_A1: begin
            mul_coef = a1_ff;
            mul_word = w1_ff;
         end
         ST_MUL_A2: begin
            mul_coef = a2_ff;
            mul_word = w2_ff;
         end
         ST_MUL_B0: begin
            mul_coef = b0_ff;
            mul_word = d_ff;
         end
         ST_MUL_B1: begin
            mul_coef = b1_ff;
            mul_word = w1_ff;
         end
         ST_MUL_B2: begin
            mul_coef = b2_ff;
            mul_word = w2_ff;
         end
         default: begin
            mul_coef = a1_ff;
            mul_word = w1_ff;
         end
      endcase
   end

   assign mul_result = PROD_BITS'(mul_coef * mul_word);

   // node: round half up to the state format, then saturate
   assign d_round = acc_ff + D_HALF;
   assign d_upper = d_round[ACC_BITS-1:D_SHIFT+STATE_BITS-1];
   assign d_fits  = (&d_upper) || !(|d_upper);
   assign d_sat   = d_fits ? d_round[D_SHIFT +: STATE_BITS]
                  : (d_round[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                         : {1'b0, {(STATE_BITS-1){1'b1}}});

   // output: round half up to the sample format, then saturate
   assign y_round = acc_ff + Y_HALF;
   assign y_upper = y_round[ACC_BITS-1:Y_SHIFT+SAMPLE_BITS-1];
   assign y_fits  = (&y_upper) || !(|y_upper);
   assign y_sat   = y_fits ? y_round[Y_SHIFT +: SAMPLE_BITS]
                  : (y_round[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

   // sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      d_in           = d_ff;
      w1_in          = w1_ff;
      w2_in          = w2_ff;
      clip_in        = clip_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // input aligned to the accumulator fraction
               acc_in   = ACC_BITS'(req_payload.sample_in) <<< X_SHIFT;
               last_in  = req_payload.last_in;
               clip_in  = 1'b0;
               state_in = ST_MUL_A1;
            end
         end
         ST_MUL_A1: begin
            prod_in  = mul_result;
            state_in = ST_MUL_A2;
         end
         ST_MUL_A2: begin
            acc_in   = acc_ff - ACC_BITS'(prod_ff);
            prod_in  = mul_result;
            state_in = ST_SUB_A2;
         end
         ST_SUB_A2: begin
            acc_in   = acc_ff - ACC_BITS'(prod_ff);
            state_in = ST_NODE;
         end
         ST_NODE: begin
            d_in     = d_sat;
            clip_in  = !d_fits;
            acc_in   = '0;
            state_in = ST_MUL_B0;
         end
         ST_MUL_B0: begin
            prod_in  = mul_result;
            state_in = ST_MUL_B1;
         end
         ST_MUL_B1: begin
            acc_in   = acc_ff + ACC_BITS'(prod_ff);
            prod_in  = mul_result;
            state_in = ST_MUL_B2;
         end
         ST_MUL_B2: begin
            acc_in   = acc_ff + ACC_BITS'(prod_ff);
            prod_in  = mul_result;
            state_in = ST_ADD_B2;
         end
         ST_ADD_B2: begin
            acc_in   = acc_ff + ACC_BITS'(prod_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_hold) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.sample_out = y_sat;
               rsp_payload_in.clipped    = clip_ff || !y_fits;
               rsp_payload_in.last_out   = last_ff;
               w2_in                     = w1_ff;
               w1_in                     = d_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         w1_ff        <= '0;
         w2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         w1_ff        <= w1_in;
         w2_ff        <= w2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      d_ff           <= d_in;
      clip_ff        <= clip_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // coefficient registers, writes beyond the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_B0:  b0_ff <= csr_data;
            CSR_B1:  b1_ff <= csr_data;
            CSR_B2:  b2_ff <= csr_data;
            CSR_A1:  a1_ff <= csr_data;
            CSR_A2:  a2_ff <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/bdf2_checker.sv
// port-level checks for the biquad unit and the bind that attaches them
module bdf2_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input bdf2_pkg::rsp_payload_type           rsp_payload,
   input logic                                csr_valid,
   input logic                                csr_ready
);
   import bdf2_pkg::*;

   // a stalled response keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // one request at a time through the shared unit
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // a response never rises too early after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("response too early after request");

   // configuration port never stalls
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("coefficient write stalled");

endmodule

bind biquad_df2_filter_unit bdf2_checker u_bdf2_checker (.*);

>>> tb/tb.sv
// self-checking testbench for the direct form II biquad filter unit
`timescale 1ns / 100ps

module tb;
   import bdf2_pkg::*;

   // 128-bit signed value, wide enough to hold every product and sum exactly
   typedef logic signed [127:0] wide_t;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SAMPLE_TARGET = 1450;
   localparam int MAX_IDLE = 11;

   localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // ---------------------------------------------------------------------
   // filter tracker: shadow coefficients and delay words, expected outputs
   // ---------------------------------------------------------------------
   class filter_tracker;
      logic signed [COEF_BITS-1:0]  coef [5];
      logic signed [STATE_BITS-1:0] delay_1;
      logic signed [STATE_BITS-1:0] delay_2;
      rsp_payload_type              expected_outputs [$];
      int                           error_count;
      int                           checked_count;
      int                           clip_count;

      function new();
         coef[CSR_B0] = COEF_ONE;
         coef[CSR_B1] = '0;
         coef[CSR_B2] = '0;
         coef[CSR_A1] = '0;
         coef[CSR_A2] = '0;
         delay_1 = '0;
         delay_2 = '0;
         error_count = 0;
         checked_count = 0;
         clip_count = 0;
      endfunction

      function wide_t to_wide(input logic signed [63:0] v);
         return v;
      endfunction

      // clamp to a signed field of the given width, flag when it clips
      function logic signed [63:0] clamp(input wide_t v, input int bits, inout logic clip);
         wide_t top;
         wide_t bottom;
         top = (to_wide(1) <<< (bits - 1)) - to_wide(1);
         bottom = -top - to_wide(1);
         if (v > top) begin
            clip = 1'b1;
            return top[63:0];
         end
         if (v < bottom) begin
            clip = 1'b1;
            return bottom[63:0];
         end
         return v[63:0];
      endfunction

      // out-of-range register indexes are dropped
      function void write_coef(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [COEF_BITS-1:0] data);
         if (index <= CSR_A2)
            coef[index] = data;
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      // one accepted sample: run the recursion and queue the filtered sample
      function void predict_sample(input req_payload_type p);
         wide_t                        acc;
         wide_t                        node_half;
         wide_t                        out_half;
         logic signed [STATE_BITS-1:0] node;
         logic signed [63:0]           y;
         logic                         clip;
         rsp_payload_type              e;
         clip = 1'b0;
         node_half = to_wide(1) <<< (D_SHIFT - 1);
         out_half = to_wide(1) <<< (Y_SHIFT - 1);
         // recursive node, rounded half up into the state format
         acc = to_wide(p.sample_in) <<< X_SHIFT;
         acc = acc - to_wide(coef[CSR_A1]) * to_wide(delay_1);
         acc = acc - to_wide(coef[CSR_A2]) * to_wide(delay_2);
         node = STATE_BITS'(clamp((acc + node_half) >>> D_SHIFT, STATE_BITS, clip));
         // output taps
         acc = to_wide(coef[CSR_B0]) * to_wide(node);
         acc = acc + to_wide(coef[CSR_B1]) * to_wide(delay_1);
         acc = acc + to_wide(coef[CSR_B2]) * to_wide(delay_2);
         y = clamp((acc + out_half) >>> Y_SHIFT, SAMPLE_BITS, clip);
         delay_2 = delay_1;
         delay_1 = node;
         e.sample_out = y[SAMPLE_BITS-1:0];
         e.clipped = clip;
         e.last_out = p.last_in;
         expected_outputs.push_back(e);
      endfunction

      function void check_output(input rsp_payload_type got);
         rsp_payload_type e;
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected output, expected none actual %h", $time, got);
            error_count++;
            return;
         end
         e = expected_outputs.pop_front();
         checked_count++;
         if (got.clipped)
            clip_count++;
         if (got.sample_out !== e.sample_out) begin
            $display("%0t: sample_out mismatch, expected %h actual %h",
                     $time, e.sample_out, got.sample_out);
            error_count++;
         end
         if (got.clipped !== e.clipped) begin
            $display("%0t: clipped mismatch, expected %b actual %b",
                     $time, e.clipped, got.clipped);
            error_count++;
         end
         if (got.last_out !== e.last_out) begin
            $display("%0t: last_out mismatch, expected %b actual %b",
                     $time, e.last_out, got.last_out);
            error_count++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // block under test
   // ---------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COEF_BITS-1:0]      csr_data = '0;

   biquad_df2_filter_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   filter_tracker tracker = new();

   // idle switches per phase, so some stretches run back to back
   bit req_idle = 1'b0;
   bit rsp_idle = 1'b0;

   int cycle_count = 0;
   int sent_count = 0;
   int setting_count = 0;

   // pending register writes, drained by apply_csr_writes
   logic [CSR_INDEX_BITS-1:0] csr_index_q [$];
   logic [COEF_BITS-1:0]      csr_data_q [$];

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d outputs still due", cycle_count,
                  tracker.pending());
         $display("FAILURE");
         $finish;
      end
   end

   // every handshake is observed at the rising edge; inputs only move at the falling edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.write_coef(csr_index, csr_data);
         if (req_valid && req_ready)
            tracker.predict_sample(req_payload);
         if (rsp_valid && rsp_ready)
            tracker.check_output(rsp_payload);
      end
   end

   // output side: random stall before each filtered sample is taken
   initial begin
      int stall;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         stall = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // one sample request; entered and left at a falling edge with valid still high
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic l);
      int gap;
      req_payload_type p;
      gap = req_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      p.sample_in = s;
      p.last_in = l;
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
   endtask

   // drop valid and let every filtered sample come back
   task automatic drain_samples();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
   endtask

   task automatic queue_coefs(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                              input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                              input logic [COEF_BITS-1:0] a2);
      csr_index_q.push_back(CSR_B0); csr_data_q.push_back(b0);
      csr_index_q.push_back(CSR_B1); csr_data_q.push_back(b1);
      csr_index_q.push_back(CSR_B2); csr_data_q.push_back(b2);
      csr_index_q.push_back(CSR_A1); csr_data_q.push_back(a1);
      csr_index_q.push_back(CSR_A2); csr_data_q.push_back(a2);
   endtask

   // register writes go out back to back, only with the filter idle
   task automatic apply_csr_writes();
      drain_samples();
      while (csr_index_q.size() != 0) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_q.pop_front();
         csr_data <= csr_data_q.pop_front();
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   function automatic logic [COEF_BITS-1:0] coef_around(input longint lim);
      return COEF_BITS'($urandom_range(0, 32'(2 * lim)) - lim);
   endfunction

   function automatic logic [COEF_BITS-1:0] coef_corner();
      case ($urandom_range(0, 4))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3: return COEF_ONE;
         default: return -COEF_ONE;
      endcase
   endfunction

   // pick a coefficient set for one random phase
   task automatic pick_setting();
      int     style;
      longint a2;
      longint a1_lim;
      style = $urandom_range(0, 19);
      if (style < 12) begin
         // stable poles: |a2| < 0.9, |a1| < 0.95 * (1 + a2)
         a2 = longint'($urandom_range(0, 483183820)) - 241591910;
         a1_lim = ((longint'(COEF_ONE) + a2) * 95) / 100;
         queue_coefs(coef_around(longint'(COEF_ONE)), coef_around(longint'(COEF_ONE)),
                     coef_around(longint'(COEF_ONE)), coef_around(a1_lim), COEF_BITS'(a2));
      end else if (style < 15) begin
         queue_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (style < 17) begin
         queue_coefs(coef_corner(), coef_corner(), coef_corner(), coef_corner(),
                     coef_corner());
      end else begin
         // back to pass-through, which also flushes a saturated state
         queue_coefs(COEF_ONE, '0, '0, '0, '0);
      end
      // now and then a write to an unused index, which must change nothing
      if ($urandom_range(0, 3) == 0) begin
         csr_index_q.push_back(CSR_INDEX_BITS'($urandom_range(CSR_A2 + 1, 7)));
         csr_data_q.push_back($urandom);
      end
   endtask

   initial begin
      int                           phase_len;
      int                           shift;
      logic signed [SAMPLE_BITS-1:0] s;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pass-through at reset coefficients, sample extremes
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample('0, 1'b0);
      send_sample('1, 1'b1);
      send_sample(24'd1, 1'b0);
      send_sample(24'h555555, 1'b0);
      send_sample(24'haaaaaa, 1'b1);

      // half gain: odd samples land on a rounding tie
      queue_coefs(COEF_ONE >> 1, '0, '0, '0, '0);
      apply_csr_writes();
      send_sample(24'd1, 1'b0);
      send_sample('1, 1'b0);
      send_sample(24'd3, 1'b1);
      send_sample(-24'sd3, 1'b0);

      // largest gain: output clips both ways
      queue_coefs(COEF_MAX, '0, '0, '0, '0);
      apply_csr_writes();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(24'd1, 1'b0);

      // strongest feedback: the delay words run into saturation
      queue_coefs(COEF_ONE, '0, '0, COEF_MIN, COEF_MIN);
      apply_csr_writes();
      repeat (4) send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);

      // all taps at the negative extreme, plus writes to every unused index
      queue_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      for (int i = CSR_A2 + 1; i < 8; i++) begin
         csr_index_q.push_back(CSR_INDEX_BITS'(i));
         csr_data_q.push_back(COEF_ONE);
      end
      apply_csr_writes();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(24'h000123, 1'b1);

      // random phases: new coefficients, new idle pattern, mixed amplitudes
      while (sent_count < SAMPLE_TARGET) begin
         pick_setting();
         apply_csr_writes();
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(60, 160);
         if (phase_len > SAMPLE_TARGET - sent_count)
            phase_len = SAMPLE_TARGET - sent_count;
         repeat (phase_len) begin
            shift = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            s = $signed(SAMPLE_BITS'($urandom)) >>> shift;
            send_sample(s, 1'($urandom_range(0, 7) == 0));
         end
      end

      drain_samples();
      repeat (20) @(negedge clock);

      $display("ran %0d samples through %0d coefficient settings", sent_count, setting_count);
      $display("checked %0d outputs, %0d of them clipped", tracker.checked_count,
               tracker.clip_count);
      if (tracker.error_count == 0 && tracker.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
